// ===== src/upd_pkg.sv =====
// Shared types, codes and constants for the packet deframer.
package upd_pkg;

    // Defaults for the top-level parameters.
    localparam int PAYLOAD_DEPTH_DEF = 64;
    localparam int TICK_BITS_DEF     = 32;

    // Register widths and reset values.
    localparam int          CFG_INDEX_W     = 3;
    localparam int          CFG_DATA_W      = 32;
    localparam logic [7:0]  HEAD_FIRST_RST  = 8'd0;
    localparam logic [7:0]  HEAD_SECOND_RST = 8'd0;
    localparam logic [7:0]  TAIL_VALUE_RST  = 8'd0;
    localparam logic [5:0]  MAX_LENGTH_RST  = 6'd54;
    localparam logic [31:0] GAP_LIMIT_RST   = 32'd1000;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_HEAD_FIRST  = 3'd0,
        CFG_HEAD_SECOND = 3'd1,
        CFG_TAIL_VALUE  = 3'd2,
        CFG_MAX_LENGTH  = 3'd3,
        CFG_GAP_LIMIT   = 3'd4
    } cfg_index_t;

    // Parser phases of the front part.
    typedef enum logic [3:0] {
        PH_HUNT0 = 4'd0,
        PH_HUNT1 = 4'd1,
        PH_LEN0  = 4'd2,
        PH_LEN1  = 4'd3,
        PH_TYPE  = 4'd4,
        PH_CMD   = 4'd5,
        PH_SEQ   = 4'd6,
        PH_DATA  = 4'd7,
        PH_SUM0  = 4'd8,
        PH_SUM1  = 4'd9,
        PH_TAIL  = 4'd10
    } phase_t;

    // States of the result sequencer in the back part.
    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_HEAD = 2'd1,
        BK_READ = 2'd2,
        BK_DATA = 2'd3
    } back_state_t;

    // Configuration register set.
    typedef struct packed {
        logic [7:0]  head_first;
        logic [7:0]  head_second;
        logic [7:0]  tail_value;
        logic [5:0]  max_length;
        logic [31:0] gap_limit;
    } upd_cfg_t;

    // One received byte transaction.
    typedef struct packed {
        logic [7:0]  rx_byte;
        logic [31:0] tick_stamp;
    } upd_in_t;

    // One result transaction.
    typedef struct packed {
        logic [7:0] frame_type;
        logic [7:0] frame_command;
        logic [7:0] frame_sequence;
        logic [5:0] payload_length;
        logic [7:0] payload_byte;
        logic       is_payload;
        logic       last;
    } upd_out_t;

    // Descriptor of a checked frame, passed from front to back.
    typedef struct packed {
        logic [7:0] frame_type;
        logic [7:0] frame_command;
        logic [7:0] frame_sequence;
        logic [5:0] payload_length;
        logic       bank;
    } upd_desc_t;

endpackage

// ===== src/uart_packet_deframer.sv =====
// Top level of the packet deframer: configuration registers and part wiring.
//
// Channel   Ports                           Transaction
// rx_item   push, full, rx_item             push && !full
// result    empty, pop, result              pop && !empty
// config    cfg_we, cfg_index, cfg_data     cfg_we
//
// The front parser takes one byte per cycle while full is low and checks a frame
// as it arrives. A checked frame is drained by the back part: the header result
// takes descriptor pickup, then the output register; each payload result takes a
// payload RAM read, then the output register.
// Two frame buffers exist; full is high while both hold frames not yet drained.
// Reset clears control state and loads register defaults; the payload RAM
// needs no clearing pass since every entry is written before it is read.
module uart_packet_deframer
    import upd_pkg::*;
#(
    parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF,
    parameter int TICK_BITS     = TICK_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   push,
    output logic                   full,
    input  upd_in_t                rx_item,
    output logic                   empty,
    input  logic                   pop,
    output upd_out_t               result
);

    localparam int AW = $clog2(PAYLOAD_DEPTH);

    upd_cfg_t  cfg_reg;
    logic      take;
    logic      mem_we;
    logic      mem_bank;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_data;
    logic      desc_push;
    upd_desc_t push_desc;
    logic      q_full;
    logic      q_valid;
    upd_desc_t head;
    logic      desc_pop;
    logic      rd_en;
    logic      rd_bank;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.head_first  <= HEAD_FIRST_RST;
            cfg_reg.head_second <= HEAD_SECOND_RST;
            cfg_reg.tail_value  <= TAIL_VALUE_RST;
            cfg_reg.max_length  <= MAX_LENGTH_RST;
            cfg_reg.gap_limit   <= GAP_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_HEAD_FIRST:  cfg_reg.head_first  <= cfg_data[7:0];
                CFG_HEAD_SECOND: cfg_reg.head_second <= cfg_data[7:0];
                CFG_TAIL_VALUE:  cfg_reg.tail_value  <= cfg_data[7:0];
                CFG_MAX_LENGTH:  cfg_reg.max_length  <= cfg_data[5:0];
                CFG_GAP_LIMIT:   cfg_reg.gap_limit   <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // Input is held off while both frame buffers wait for the back part.
    assign full = q_full;
    assign take = push && !q_full;

    upd_front #(
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH),
        .TICK_BITS     (TICK_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .take      (take),
        .in_item   (rx_item),
        .mem_we    (mem_we),
        .mem_bank  (mem_bank),
        .mem_addr  (mem_addr),
        .mem_data  (mem_data),
        .desc_push (desc_push),
        .desc      (push_desc)
    );

    upd_payload_ram #(
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_bank (mem_bank),
        .wr_addr (mem_addr),
        .wr_data (mem_data),
        .rd_en   (rd_en),
        .rd_bank (rd_bank),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    upd_frame_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_en   (desc_push),
        .push_desc (push_desc),
        .pop_en    (desc_pop),
        .q_full    (q_full),
        .q_valid   (q_valid),
        .head      (head)
    );

    upd_back #(
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc_valid (q_valid),
        .desc       (head),
        .desc_pop   (desc_pop),
        .rd_en      (rd_en),
        .rd_bank    (rd_bank),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .empty      (empty),
        .pop        (pop),
        .result     (result)
    );

endmodule

// ===== src/upd_payload_ram.sv =====
// Two-bank payload store: one write port, one registered read port.
module upd_payload_ram
    import upd_pkg::*;
#(
    parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF,
    localparam int AW = $clog2(PAYLOAD_DEPTH)
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic          wr_bank,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic          rd_bank,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [0:1][0:PAYLOAD_DEPTH-1];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_bank][wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_bank][rd_addr];
        end
    end

endmodule

// ===== src/upd_front.sv =====
// Front part: byte parser with gap timeout, length, checksum and tail checks.
module upd_front
    import upd_pkg::*;
#(
    parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF,
    parameter int TICK_BITS     = TICK_BITS_DEF,
    localparam int AW = $clog2(PAYLOAD_DEPTH)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  upd_cfg_t      cfg,
    input  logic          take,
    input  upd_in_t       in_item,
    output logic          mem_we,
    output logic          mem_bank,
    output logic [AW-1:0] mem_addr,
    output logic [7:0]    mem_data,
    output logic          desc_push,
    output upd_desc_t     desc
);

    localparam int CW = (TICK_BITS > 32) ? TICK_BITS : 32;
    localparam logic [AW-1:0] LAST_ADDR = AW'(PAYLOAD_DEPTH - 1);

    phase_t phase_reg, phase_next, phase_eff;

    logic [TICK_BITS-1:0] prev_tick_reg, prev_tick_next;
    logic [7:0]  len_low_reg, len_low_next;
    logic [5:0]  len_reg, len_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [7:0]  seq_reg, seq_next;
    logic [5:0]  count_reg, count_next;
    logic [AW-1:0] widx_reg, widx_next;
    logic [15:0] sum_reg, sum_next;
    logic [7:0]  sum_low_reg, sum_low_next;
    logic        bank_reg, bank_next;

    logic [TICK_BITS-1:0] now;
    logic [TICK_BITS-1:0] gap;
    logic        gap_over;
    logic [7:0]  b;
    logic [15:0] sum_add;
    logic [5:0]  count_inc;
    logic        len_ok;
    logic        sum_ok;
    logic        tail_ok;

    // Arrival gap, modulo the tick width, against the limit.
    assign b        = in_item.rx_byte;
    assign now      = TICK_BITS'(in_item.tick_stamp);
    assign gap      = now - prev_tick_reg;
    assign gap_over = CW'(gap) > CW'(cfg.gap_limit);
    assign phase_eff = gap_over ? PH_HUNT0 : phase_reg;

    // Shared checks.
    assign sum_add   = sum_reg + {8'd0, b};
    assign count_inc = count_reg + 6'd1;
    assign len_ok    = (b == 8'd0) && (len_low_reg <= {2'b00, cfg.max_length});
    assign sum_ok    = {b, sum_low_reg} == sum_reg;
    assign tail_ok   = b == cfg.tail_value;

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (take)
        begin
            case (phase_eff)
                PH_HUNT0: phase_next = (b == cfg.head_first) ? PH_HUNT1 : PH_HUNT0;
                PH_HUNT1:
                begin
                    if (b == cfg.head_second)
                    begin
                        phase_next = PH_LEN0;
                    end
                    else if (b != cfg.head_first)
                    begin
                        phase_next = PH_HUNT0;
                    end
                    else
                    begin
                        phase_next = PH_HUNT1;
                    end
                end
                PH_LEN0: phase_next = PH_LEN1;
                PH_LEN1: phase_next = len_ok ? PH_TYPE : PH_HUNT0;
                PH_TYPE: phase_next = PH_CMD;
                PH_CMD:  phase_next = PH_SEQ;
                PH_SEQ:  phase_next = (len_reg != 6'd0) ? PH_DATA : PH_SUM0;
                PH_DATA: phase_next = (count_inc == len_reg) ? PH_SUM0 : PH_DATA;
                PH_SUM0: phase_next = PH_SUM1;
                PH_SUM1: phase_next = sum_ok ? PH_TAIL : PH_HUNT0;
                PH_TAIL: phase_next = PH_HUNT0;
                default: phase_next = PH_HUNT0;
            endcase
        end
    end

    // Field capture, checksum, payload writes and frame hand-off.
    always_comb
    begin
        prev_tick_next = prev_tick_reg;
        len_low_next   = len_low_reg;
        len_next       = len_reg;
        type_next      = type_reg;
        cmd_next       = cmd_reg;
        seq_next       = seq_reg;
        count_next     = count_reg;
        widx_next      = widx_reg;
        sum_next       = sum_reg;
        sum_low_next   = sum_low_reg;
        bank_next      = bank_reg;
        mem_we         = 1'b0;
        desc_push      = 1'b0;
        if (take)
        begin
            prev_tick_next = now;
            case (phase_eff)
                PH_LEN0: len_low_next = b;
                PH_LEN1:
                begin
                    if (len_ok)
                    begin
                        len_next = len_low_reg[5:0];
                    end
                end
                PH_TYPE:
                begin
                    type_next = b;
                    sum_next  = {8'd0, b};
                end
                PH_CMD:
                begin
                    cmd_next = b;
                    sum_next = sum_add;
                end
                PH_SEQ:
                begin
                    seq_next   = b;
                    sum_next   = sum_add;
                    count_next = 6'd0;
                    widx_next  = '0;
                end
                PH_DATA:
                begin
                    mem_we     = 1'b1;
                    sum_next   = sum_add;
                    count_next = count_inc;
                    widx_next  = (widx_reg == LAST_ADDR) ? '0 : widx_reg + AW'(1);
                end
                PH_SUM0: sum_low_next = b;
                PH_TAIL:
                begin
                    if (tail_ok)
                    begin
                        desc_push = 1'b1;
                        bank_next = ~bank_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    assign mem_bank = bank_reg;
    assign mem_addr = widx_reg;
    assign mem_data = b;

    assign desc.frame_type     = type_reg;
    assign desc.frame_command  = cmd_reg;
    assign desc.frame_sequence = seq_reg;
    assign desc.payload_length = len_reg;
    assign desc.bank           = bank_reg;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT0;
            prev_tick_reg <= '0;
            bank_reg      <= 1'b0;
            count_reg     <= 6'd0;
            widx_reg      <= '0;
            len_reg       <= 6'd0;
        end
        else
        begin
            phase_reg     <= phase_next;
            prev_tick_reg <= prev_tick_next;
            bank_reg      <= bank_next;
            count_reg     <= count_next;
            widx_reg      <= widx_next;
            len_reg       <= len_next;
        end
    end

    // Captured fields and checksum.
    always_ff @(posedge clk)
    begin
        len_low_reg <= len_low_next;
        type_reg    <= type_next;
        cmd_reg     <= cmd_next;
        seq_reg     <= seq_next;
        sum_reg     <= sum_next;
        sum_low_reg <= sum_low_next;
    end

endmodule

// ===== src/upd_frame_queue.sv =====
// Two-entry queue of checked frame descriptors between front and back.
module upd_frame_queue
    import upd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_en,
    input  upd_desc_t push_desc,
    input  logic      pop_en,
    output logic      q_full,
    output logic      q_valid,
    output upd_desc_t head
);

    upd_desc_t  ent_reg [0:1];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign q_full  = count_reg == 2'd2;
    assign q_valid = count_reg != 2'd0;
    assign head    = ent_reg[rptr_reg];
    assign do_push = push_en && !q_full;
    assign do_pop  = pop_en && q_valid;

    // Pointer and occupancy update.
    always_comb
    begin
        wptr_next  = do_push ? ~wptr_reg : wptr_reg;
        rptr_next  = do_pop ? ~rptr_reg : rptr_reg;
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ent_reg[wptr_reg] <= push_desc;
        end
    end

endmodule

// ===== src/upd_back.sv =====
// Back part: turns a frame descriptor into header and payload results.
module upd_back
    import upd_pkg::*;
#(
    parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF,
    localparam int AW = $clog2(PAYLOAD_DEPTH)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          desc_valid,
    input  upd_desc_t     desc,
    output logic          desc_pop,
    output logic          rd_en,
    output logic          rd_bank,
    output logic [AW-1:0] rd_addr,
    input  logic [7:0]    rd_data,
    output logic          empty,
    input  logic          pop,
    output upd_out_t      result
);

    localparam logic [AW-1:0] LAST_ADDR = AW'(PAYLOAD_DEPTH - 1);

    back_state_t state_reg, state_next;
    logic [5:0]    cnt_reg, cnt_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic          out_valid_reg, out_valid_next;
    upd_out_t      out_reg, out_next;

    logic       can_load;
    logic       load_head;
    logic       load_data;
    logic       data_last;
    logic [5:0] cnt_inc;

    assign can_load  = !out_valid_reg || pop;
    assign cnt_inc   = cnt_reg + 6'd1;
    assign data_last = cnt_inc == desc.payload_length;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: state_next = desc_valid ? BK_HEAD : BK_IDLE;
            BK_HEAD:
            begin
                if (can_load)
                begin
                    state_next = (desc.payload_length == 6'd0) ? BK_IDLE : BK_READ;
                end
            end
            BK_READ: state_next = BK_DATA;
            BK_DATA:
            begin
                if (can_load)
                begin
                    state_next = data_last ? BK_IDLE : BK_READ;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // State outputs.
    always_comb
    begin
        load_head = 1'b0;
        load_data = 1'b0;
        rd_en     = 1'b0;
        desc_pop  = 1'b0;
        cnt_next  = cnt_reg;
        addr_next = addr_reg;
        case (state_reg)
            BK_HEAD:
            begin
                if (can_load)
                begin
                    load_head = 1'b1;
                    desc_pop  = desc.payload_length == 6'd0;
                    cnt_next  = 6'd0;
                    addr_next = '0;
                end
            end
            BK_READ: rd_en = 1'b1;
            BK_DATA:
            begin
                if (can_load)
                begin
                    load_data = 1'b1;
                    desc_pop  = data_last;
                    cnt_next  = cnt_inc;
                    addr_next = (addr_reg == LAST_ADDR) ? '0 : addr_reg + AW'(1);
                end
            end
            default: ;
        endcase
    end

    assign rd_bank = desc.bank;
    assign rd_addr = addr_reg;

    // Output register: loaded from the sequencer, drained by pop.
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !pop;
        if (load_head || load_data)
        begin
            out_next.frame_type     = desc.frame_type;
            out_next.frame_command  = desc.frame_command;
            out_next.frame_sequence = desc.frame_sequence;
            out_next.payload_length = desc.payload_length;
            out_next.payload_byte   = load_data ? rd_data : 8'd0;
            out_next.is_payload     = load_data;
            out_next.last           = load_data ? data_last
                                                : (desc.payload_length == 6'd0);
            out_valid_next          = 1'b1;
        end
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            cnt_reg       <= 6'd0;
            addr_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            addr_reg      <= addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule
